// ===== hw/rtl/bb3_pkg.sv =====
// Shared types, constants and helpers for the 3x3 RGB box blur.
// Used by every module of the block; no dependencies.
package bb3_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int MAX_HEIGHT    = 4096;

    localparam int FW_W   = 11;
    localparam int FH_W   = 13;
    localparam int CFG_W  = 13;
    localparam int ROW_W  = 13;
    localparam int CH_W   = 8;
    localparam int PIX_W  = 3 * CH_W;
    localparam int SUM_W  = 12;

    localparam logic [FW_W-1:0] WIDTH_RST  = 11'd800;
    localparam logic [FH_W-1:0] HEIGHT_RST = 13'd600;

    localparam int FIFO_DEPTH = 4;

    localparam logic [12:0] DIV9_RECIP = 13'd7282;

    typedef enum logic {
        OP_PIXEL = 1'b0,
        OP_FLUSH = 1'b1
    } t_op;

    typedef enum logic {
        REG_WIDTH  = 1'b0,
        REG_HEIGHT = 1'b1
    } t_reg;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_pix;

    typedef struct packed {
        t_pix top;
        t_pix mid;
        t_pix bot;
    } t_col;

    typedef struct packed {
        logic valid;
        logic first_col;
        logic has_top;
        logic has_mid;
        logic wr_en;
        logic emit;
        logic last;
        t_pix bot;
    } t_adv;

    typedef struct packed {
        logic [SUM_W-1:0] red;
        logic [SUM_W-1:0] green;
        logic [SUM_W-1:0] blue;
    } t_sums;

    function automatic logic [CH_W-1:0] div9(input logic [SUM_W-1:0] s);
        logic [SUM_W+12:0] p;
        p = (SUM_W+13)'(s) * (SUM_W+13)'(DIV9_RECIP);
        return p[23:16];
    endfunction

endpackage

// ===== hw/rtl/box_blur_3x3_rgb.sv =====
// 3x3 box blur over a raster RGB stream: each result is the per-channel sum of a
// pixel's 3x3 neighborhood divided by nine (truncated), outside pixels counted as
// zero. The block takes one request per clock while the result queue has room and
// gives at most one result per request, through the line-memory and window registers
// into the queue, from the request one row and one pixel after its position. One line
// memory of MAX_WIDTH entries of 48 bits, read when a request is taken and
// written back the next cycle, sets that rate; no clearing pass runs after
// reset. Flush requests drain the results left after the last pixel, one per
// flush: a row plus one, or a single row on a frame of height one, where the
// first flush of a row-start position holds ready low for one cycle.
// Pixels sent while results are still pending, and flushes during a frame, are
// taken and dropped. Frame size registers may be written only when idle; a
// write restarts the frame. A four-entry result queue decouples the output.
module box_blur_3x3_rgb import bb3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic             i_cfg_index,
    input  logic [CFG_W-1:0] i_cfg_data,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic             i_operation,
    input  logic [CH_W-1:0]  i_in_red,
    input  logic [CH_W-1:0]  i_in_green,
    input  logic [CH_W-1:0]  i_in_blue,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CH_W-1:0]  o_out_red,
    output logic [CH_W-1:0]  o_out_green,
    output logic [CH_W-1:0]  o_out_blue,
    output logic             o_frame_end
);

    localparam int CW  = $clog2(MAX_WIDTH);
    localparam int CNW = $clog2(FIFO_DEPTH + 1);

    t_pix           in_pix;
    t_pix           out_pix;
    t_adv           w_adv;
    t_adv           w_s1;
    logic [CW-1:0]  w_col;
    t_pix           w_top, w_mid;
    logic           w_s2_valid;
    t_sums          w_sums;
    logic           w_s2_last;
    logic [CNW-1:0] w_cnt;
    logic [CNW:0]   occ;
    logic           w_space;

    assign in_pix.red   = i_in_red;
    assign in_pix.green = i_in_green;
    assign in_pix.blue  = i_in_blue;

    assign occ     = (CNW+1)'(w_cnt) + (CNW+1)'(w_s1.valid) + (CNW+1)'(w_s2_valid);
    assign w_space = (occ <= (CNW+1)'(FIFO_DEPTH - 1));

    bb3_ctrl #(.MAX_WIDTH(MAX_WIDTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_pix       (in_pix),
        .i_space     (w_space),
        .o_ready     (o_ready),
        .o_adv       (w_adv),
        .o_col       (w_col)
    );

    bb3_line_mem #(.MAX_WIDTH(MAX_WIDTH)) u_line_mem (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_adv   (w_adv),
        .i_col   (w_col),
        .o_adv   (w_s1),
        .o_top   (w_top),
        .o_mid   (w_mid)
    );

    bb3_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_clear (i_cfg_we),
        .i_adv   (w_s1),
        .i_top   (w_top),
        .i_mid   (w_mid),
        .o_valid (w_s2_valid),
        .o_sums  (w_sums),
        .o_last  (w_s2_last)
    );

    bb3_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_wr        (w_s2_valid),
        .i_sums      (w_sums),
        .i_last      (w_s2_last),
        .i_ready     (i_ready),
        .o_valid     (o_valid),
        .o_pix       (out_pix),
        .o_frame_end (o_frame_end),
        .o_cnt       (w_cnt)
    );

    assign o_out_red   = out_pix.red;
    assign o_out_green = out_pix.green;
    assign o_out_blue  = out_pix.blue;

    a_queue_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_s2_valid |-> (w_cnt < CNW'(FIFO_DEPTH)) || (o_valid && i_ready))
        else $error("result queue written while full");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cnt <= CNW'(FIFO_DEPTH))
        else $error("result queue count out of range");

    a_extra_step_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv.valid && !o_ready) |=> !(w_adv.valid && !o_ready))
        else $error("flush took more than one internal step");

endmodule

// ===== hw/rtl/bb3_ctrl.sv =====
// Raster position counters, frame registers and request decode.
// Depends on bb3_pkg.
module bb3_ctrl import bb3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data,
    input  logic                         i_valid,
    input  logic                         i_operation,
    input  t_pix                         i_pix,
    input  logic                         i_space,
    output logic                         o_ready,
    output t_adv                         o_adv,
    output logic [$clog2(MAX_WIDTH)-1:0] o_col
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [FW_W-1:0]  r_width;
    logic [FH_W-1:0]  r_height;
    logic [CW-1:0]    r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic [CW-1:0]    last_col;
    logic [ROW_W-1:0] eff_h;
    logic             virt, first_col, has_top, has_mid, emit, last;
    logic             is_flush, act, extra, fire;

    always_comb begin
        if (r_width == '0) begin
            last_col = '0;
        end else if (32'(r_width) > MAX_WIDTH) begin
            last_col = CW'(MAX_WIDTH - 1);
        end else begin
            last_col = CW'(32'(r_width) - 32'd1);
        end
        if (r_height == '0) begin
            eff_h = ROW_W'(1);
        end else if (32'(r_height) > MAX_HEIGHT) begin
            eff_h = ROW_W'(MAX_HEIGHT);
        end else begin
            eff_h = r_height;
        end
    end

    assign virt      = (r_row >= eff_h);
    assign first_col = (r_col == '0);
    assign has_mid   = (r_row != '0);
    assign has_top   = (r_row >= ROW_W'(2));
    assign emit      = first_col ? has_top : has_mid;
    assign last      = emit && first_col && (r_row == eff_h + ROW_W'(1));
    assign is_flush  = (i_operation == OP_FLUSH);
    assign act       = is_flush ? virt : !virt;
    assign extra     = is_flush && act && !emit;
    assign fire      = i_valid && i_space && act;
    assign o_ready   = i_space && !extra;

    always_comb begin
        o_adv.valid     = fire;
        o_adv.first_col = first_col;
        o_adv.has_top   = has_top;
        o_adv.has_mid   = has_mid;
        o_adv.wr_en     = !virt;
        o_adv.emit      = emit;
        o_adv.last      = last;
        o_adv.bot       = virt ? '0 : i_pix;
    end

    assign o_col = r_col;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_cfg_we) begin
            n_col = '0;
            n_row = '0;
        end else if (fire) begin
            if (last) begin
                n_col = '0;
                n_row = '0;
            end else if (r_col == last_col) begin
                n_col = '0;
                n_row = r_row + ROW_W'(1);
            end else begin
                n_col = r_col + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
            r_col    <= '0;
            r_row    <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
            if (i_cfg_we) begin
                case (t_reg'(i_cfg_index))
                    REG_WIDTH:  r_width  <= i_cfg_data[FW_W-1:0];
                    REG_HEIGHT: r_height <= i_cfg_data[FH_W-1:0];
                    default: ;
                endcase
            end
        end
    end

endmodule

// ===== hw/rtl/bb3_line_mem.sv =====
// Two-row line memory, one entry per column holding the two previous rows.
// Read at request time, written back in the following cycle with forwarding. Uses bb3_pkg.
module bb3_line_mem import bb3_pkg::*; #(
    parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  t_adv                         i_adv,
    input  logic [$clog2(MAX_WIDTH)-1:0] i_col,
    output t_adv                         o_adv,
    output t_pix                         o_top,
    output t_pix                         o_mid
);

    localparam int CW = $clog2(MAX_WIDTH);

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] r_rd;
    logic [2*PIX_W-1:0] r_fwd;
    logic               r_fwd_hit;
    t_adv               r_s1;
    logic [CW-1:0]      r_s1_col;
    logic [2*PIX_W-1:0] word;
    logic [2*PIX_W-1:0] wdata;
    logic               we;

    assign word  = r_fwd_hit ? r_fwd : r_rd;
    assign o_top = r_s1.has_top ? t_pix'(word[2*PIX_W-1:PIX_W]) : '0;
    assign o_mid = r_s1.has_mid ? t_pix'(word[PIX_W-1:0]) : '0;
    assign wdata = {o_mid, r_s1.bot};
    assign we    = r_s1.valid && r_s1.wr_en;
    assign o_adv = r_s1;

    always_ff @(posedge i_clk) begin
        if (i_adv.valid) begin
            r_rd <= mem[i_col];
        end
        if (we) begin
            mem[r_s1_col] <= wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1      <= '0;
            r_fwd_hit <= 1'b0;
        end else begin
            r_s1      <= i_adv;
            r_fwd_hit <= i_adv.valid && we && (i_col == r_s1_col);
        end
        r_s1_col <= i_col;
        r_fwd    <= wdata;
    end

endmodule

// ===== hw/rtl/bb3_window.sv =====
// 3x3 window registers and per-channel neighborhood sums.
// Depends on bb3_pkg.
module bb3_window import bb3_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_clear,
    input  t_adv  i_adv,
    input  t_pix  i_top,
    input  t_pix  i_mid,
    output logic  o_valid,
    output t_sums o_sums,
    output logic  o_last
);

    t_col  r_c1, r_c2;
    t_col  n_c1, n_c2;
    t_col  new_col, e2;
    t_sums sums;
    logic  r_valid;
    logic  r_last;
    t_sums r_sums;

    function automatic logic [SUM_W-1:0] sum_col(input logic [CH_W-1:0] a,
                                                 input logic [CH_W-1:0] b,
                                                 input logic [CH_W-1:0] c);
        return SUM_W'(a) + SUM_W'(b) + SUM_W'(c);
    endfunction

    always_comb begin
        new_col.top = i_top;
        new_col.mid = i_mid;
        new_col.bot = i_adv.bot;
        e2 = i_adv.first_col ? t_col'('0) : new_col;

        sums.red   = sum_col(r_c1.top.red, r_c1.mid.red, r_c1.bot.red)
                   + sum_col(r_c2.top.red, r_c2.mid.red, r_c2.bot.red)
                   + sum_col(e2.top.red, e2.mid.red, e2.bot.red);
        sums.green = sum_col(r_c1.top.green, r_c1.mid.green, r_c1.bot.green)
                   + sum_col(r_c2.top.green, r_c2.mid.green, r_c2.bot.green)
                   + sum_col(e2.top.green, e2.mid.green, e2.bot.green);
        sums.blue  = sum_col(r_c1.top.blue, r_c1.mid.blue, r_c1.bot.blue)
                   + sum_col(r_c2.top.blue, r_c2.mid.blue, r_c2.bot.blue)
                   + sum_col(e2.top.blue, e2.mid.blue, e2.bot.blue);

        n_c1 = r_c1;
        n_c2 = r_c2;
        if (i_clear || (i_adv.valid && i_adv.last)) begin
            n_c1 = '0;
            n_c2 = '0;
        end else if (i_adv.valid) begin
            if (i_adv.first_col) begin
                n_c1 = '0;
                n_c2 = new_col;
            end else begin
                n_c1 = r_c2;
                n_c2 = new_col;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1    <= '0;
            r_c2    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_c1    <= n_c1;
            r_c2    <= n_c2;
            r_valid <= i_adv.valid && i_adv.emit;
        end
        r_sums <= sums;
        r_last <= i_adv.last;
    end

    assign o_valid = r_valid;
    assign o_sums  = r_sums;
    assign o_last  = r_last;

endmodule

// ===== hw/rtl/bb3_out_fifo.sv =====
// Divide-by-nine and result queue toward the output channel.
// Depends on bb3_pkg.
module bb3_out_fifo import bb3_pkg::*; (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_wr,
    input  t_sums                           i_sums,
    input  logic                            i_last,
    input  logic                            i_ready,
    output logic                            o_valid,
    output t_pix                            o_pix,
    output logic                            o_frame_end,
    output logic [$clog2(FIFO_DEPTH+1)-1:0] o_cnt
);

    localparam int AW  = $clog2(FIFO_DEPTH);
    localparam int CNW = $clog2(FIFO_DEPTH + 1);

    typedef struct packed {
        t_pix pix;
        logic frame_end;
    } t_res;

    t_res           r_mem [FIFO_DEPTH];
    logic [AW-1:0]  r_wr_ptr, r_rd_ptr;
    logic [CNW-1:0] r_cnt;
    logic           pop;
    t_res           wr_res;

    assign pop = o_valid && i_ready;

    always_comb begin
        wr_res.pix.red   = div9(i_sums.red);
        wr_res.pix.green = div9(i_sums.green);
        wr_res.pix.blue  = div9(i_sums.blue);
        wr_res.frame_end = i_last;
    end

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= wr_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= (r_wr_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(FIFO_DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            case ({i_wr, pop})
                2'b10:   r_cnt <= r_cnt + CNW'(1);
                2'b01:   r_cnt <= r_cnt - CNW'(1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_valid     = (r_cnt != '0);
    assign o_pix       = r_mem[r_rd_ptr].pix;
    assign o_frame_end = r_mem[r_rd_ptr].frame_end;
    assign o_cnt       = r_cnt;

endmodule
